// ===== hw/rtl/mh_pkg.sv =====
// ----------------------------------------------------------------------------
// mh_pkg
// Types, widths and constants shared by the magnetometer heading pipeline.
// ----------------------------------------------------------------------------
package mh_pkg;

  localparam int XY_W     = 32;
  localparam int Z_W      = 34;
  localparam int H_W      = 36;
  localparam int PRESCALE = 16;
  localparam int ATAN_LEN = 24;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [H_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

  typedef enum logic [1:0] {
    REG_X_OFFSET    = 2'd0,
    REG_Y_OFFSET    = 2'd1,
    REG_DECLINATION = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [13:0] xc;
    logic signed [13:0] yc;
    logic signed [12:0] zr;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cell_t;

  function automatic logic signed [Z_W-1:0] atan_q30(logic [4:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 34'sd843314856;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043836;
      5'd3:    a = 34'sd133525158;
      5'd4:    a = 34'sd67021686;
      5'd5:    a = 34'sd33543515;
      5'd6:    a = 34'sd16775850;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194282;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048575;
      5'd11:   a = 34'sd524287;
      5'd12:   a = 34'sd262143;
      5'd13:   a = 34'sd131071;
      5'd14:   a = 34'sd65535;
      5'd15:   a = 34'sd32767;
      5'd16:   a = 34'sd16383;
      5'd17:   a = 34'sd8191;
      5'd18:   a = 34'sd4095;
      5'd19:   a = 34'sd2047;
      5'd20:   a = 34'sd1023;
      5'd21:   a = 34'sd511;
      5'd22:   a = 34'sd255;
      5'd23:   a = 34'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/mh_if.sv =====
// ----------------------------------------------------------------------------
// mh_if
// Valid/ready channels for magnetometer samples and heading results.
// ----------------------------------------------------------------------------
interface mh_in_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] x_raw;
  logic signed [12:0] z_raw;
  logic signed [12:0] y_raw;

  modport source (output valid, x_raw, z_raw, y_raw, input ready);
  modport sink (input valid, x_raw, z_raw, y_raw, output ready);
endinterface

interface mh_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] heading_rad;
  logic signed [13:0] x_calibrated;
  logic signed [13:0] y_calibrated;
  logic signed [12:0] z_out;

  modport source (output valid, heading_rad, x_calibrated, y_calibrated, z_out,
                  input ready);
  modport sink (input valid, heading_rad, x_calibrated, y_calibrated, z_out,
                output ready);
endinterface

// ===== hw/rtl/mh_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// mh_cordic_cell
// One vectoring CORDIC micro-rotation with its own valid/ready stage.
// ----------------------------------------------------------------------------
module mh_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  mh_pkg::cell_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output mh_pkg::cell_t dn_data
);

  localparam logic [4:0] IDX = 5'(STAGE);

  mh_pkg::cell_t                  turned;
  logic signed [mh_pkg::XY_W-1:0] dx;
  logic signed [mh_pkg::XY_W-1:0] dy;
  logic signed [mh_pkg::Z_W-1:0]  da;

  always_comb begin
    dx     = up_data.y >>> STAGE;
    dy     = up_data.x >>> STAGE;
    da     = mh_pkg::atan_q30(IDX);
    turned = up_data;
    if (up_data.y > 0) begin
      turned.x = up_data.x + dx;
      turned.y = up_data.y - dy;
      turned.z = up_data.z + da;
    end else begin
      turned.x = up_data.x - dx;
      turned.y = up_data.y + dy;
      turned.z = up_data.z - da;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= turned;
    end
  end

endmodule

// ===== hw/rtl/mh_decl_conv.sv =====
// ----------------------------------------------------------------------------
// mh_decl_conv
// Converts declination in hundredths of a degree to radians scaled by 2^30,
// rounded half away from zero. Four register stages.
// ----------------------------------------------------------------------------
module mh_decl_conv (
  input  logic                          clk,
  input  logic signed [15:0]            declination,
  output logic signed [mh_pkg::Z_W-1:0] decl_q30
);

  localparam logic [32:0] PI_WHOLE   = 33'd187403;
  localparam logic [27:0] PI_FRAC    = 28'd5426;
  localparam logic [27:0] HALF_DIV   = 28'd9000;
  localparam logic [47:0] RECIP_1125 = 48'd15270994;
  localparam logic [24:0] DIV_1125   = 25'd1125;

  logic        neg_a;
  logic [15:0] mag;
  logic [32:0] base_a;
  logic [27:0] v_a;

  logic        neg_b;
  logic [32:0] base_b;
  logic [23:0] vs_b;
  logic [13:0] q_est_b;
  logic [47:0] prod;

  logic        neg_c;
  logic [32:0] base_c;
  logic [13:0] q_c;
  logic [24:0] rem;

  logic [mh_pkg::Z_W-1:0] r;

  assign mag  = declination[15] ? 16'(-declination) : 16'(declination);
  assign prod = 48'(v_a[27:4]) * RECIP_1125;
  assign rem  = 25'(vs_b) - 25'(q_est_b) * DIV_1125;
  assign r    = mh_pkg::Z_W'(base_c) + mh_pkg::Z_W'(q_c);

  always_ff @(posedge clk) begin
    neg_a    <= declination[15];
    base_a   <= 33'(mag) * PI_WHOLE;
    v_a      <= 28'(mag) * PI_FRAC + HALF_DIV;
    neg_b    <= neg_a;
    base_b   <= base_a;
    vs_b     <= v_a[27:4];
    q_est_b  <= prod[47:34];
    neg_c    <= neg_b;
    base_c   <= base_b;
    q_c      <= q_est_b + 14'(rem >= DIV_1125);
    decl_q30 <= neg_c ? -signed'(r) : signed'(r);
  end

endmodule

// ===== hw/rtl/magnetometer_heading.sv =====
// ----------------------------------------------------------------------------
// magnetometer_heading
// Compass heading from one three-axis magnetometer sample.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless backpressure holds the front stage, and
// returns one result per sample, in order. Stages: calibration and quadrant
// fold, one cell per CORDIC iteration (capped at the arctangent table length),
// declination add, wrap, output register; the row of CORDIC cells sets the
// depth, and every stage holds its word on backpressure while bubbles ahead
// of it are filled. Registers: 0 x_offset, 1 y_offset (13 bit counts), 2
// declination (16 bit, hundredths of a degree), which reaches the heading path through the mh_decl_conv registers.
// ----------------------------------------------------------------------------
module magnetometer_heading #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  mh_in_if.sink        sample,
  mh_out_if.source     result
);

  localparam int NUM_CELLS = (CORDIC_ITERATIONS > mh_pkg::ATAN_LEN) ?
                             mh_pkg::ATAN_LEN : CORDIC_ITERATIONS;

  logic signed [12:0] x_offset;
  logic signed [12:0] y_offset;
  logic signed [15:0] declination;
  logic signed [mh_pkg::Z_W-1:0] decl_q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset    <= '0;
      y_offset    <= '0;
      declination <= '0;
    end else if (cfg_wr_en) begin
      unique case (mh_pkg::cfg_reg_t'(cfg_index))
        mh_pkg::REG_X_OFFSET:    x_offset    <= cfg_data[12:0];
        mh_pkg::REG_Y_OFFSET:    y_offset    <= cfg_data[12:0];
        mh_pkg::REG_DECLINATION: declination <= cfg_data;
        default: ;
      endcase
    end
  end

  mh_decl_conv u_decl (
    .clk        (clk),
    .declination(declination),
    .decl_q30   (decl_q30)
  );

  mh_pkg::cell_t chain_data  [NUM_CELLS+1];
  logic          chain_valid [NUM_CELLS+1];
  logic          chain_ready [NUM_CELLS+1];

  logic signed [13:0]             xc;
  logic signed [13:0]             yc;
  logic signed [mh_pkg::XY_W-1:0] xs;
  logic signed [mh_pkg::XY_W-1:0] ys;
  mh_pkg::cell_t                  front_next;
  logic                           front_ready;

  assign xc = 14'(sample.x_raw) - 14'(x_offset);
  assign yc = 14'(sample.y_raw) - 14'(y_offset);
  assign xs = mh_pkg::XY_W'(xc) <<< mh_pkg::PRESCALE;
  assign ys = mh_pkg::XY_W'(yc) <<< mh_pkg::PRESCALE;

  always_comb begin
    front_next.side.xc   = xc;
    front_next.side.yc   = yc;
    front_next.side.zr   = sample.z_raw;
    front_next.side.zero = (xc == 14'sd0) && (yc == 14'sd0);
    front_next.x         = xs;
    front_next.y         = ys;
    front_next.z         = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        front_next.x = ys;
        front_next.y = -xs;
        front_next.z = mh_pkg::HALF_PI_Q30;
      end else begin
        front_next.x = -ys;
        front_next.y = xs;
        front_next.z = -mh_pkg::HALF_PI_Q30;
      end
    end
  end

  assign front_ready  = !chain_valid[0] || chain_ready[0];
  assign sample.ready = front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (front_ready) begin
      chain_valid[0] <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && sample.valid) begin
      chain_data[0] <= front_next;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mh_cordic_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(chain_valid[k]),
      .up_ready(chain_ready[k]),
      .up_data (chain_data[k]),
      .dn_valid(chain_valid[k+1]),
      .dn_ready(chain_ready[k+1]),
      .dn_data (chain_data[k+1])
    );
  end

  logic                          sum_valid;
  logic                          sum_ready;
  logic signed [mh_pkg::H_W-1:0] sum_h;
  mh_pkg::side_t                 sum_side;
  logic signed [mh_pkg::H_W-1:0] angle;

  logic                          wrap_valid;
  logic                          wrap_ready;
  logic signed [mh_pkg::H_W-1:0] wrap_h;
  logic signed [mh_pkg::H_W-1:0] wrap_next;
  mh_pkg::side_t                 wrap_side;
  logic                          out_ready;

  assign angle = chain_data[NUM_CELLS].side.zero ? '0 :
                 mh_pkg::H_W'(chain_data[NUM_CELLS].z);
  assign sum_ready              = !sum_valid || wrap_ready;
  assign chain_ready[NUM_CELLS] = sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= chain_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && chain_valid[NUM_CELLS]) begin
      sum_h    <= angle + mh_pkg::H_W'(decl_q30);
      sum_side <= chain_data[NUM_CELLS].side;
    end
  end

  always_comb begin
    if (sum_h < 0) begin
      wrap_next = sum_h + mh_pkg::TWO_PI_Q30;
    end else if (sum_h > mh_pkg::TWO_PI_Q30) begin
      wrap_next = sum_h - mh_pkg::TWO_PI_Q30;
    end else begin
      wrap_next = sum_h;
    end
  end

  assign wrap_ready = !wrap_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid <= 1'b0;
    end else if (wrap_ready) begin
      wrap_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_ready && sum_valid) begin
      wrap_h    <= wrap_next;
      wrap_side <= sum_side;
    end
  end

  logic [mh_pkg::H_W-1:0]  rounded;
  logic [mh_pkg::H_W-18:0] hq_wide;
  logic [15:0]             hq;

  assign rounded = unsigned'(wrap_h) + mh_pkg::H_W'(65536);
  assign hq_wide = rounded[mh_pkg::H_W-1:17];

  always_comb begin
    if (wrap_h < 0) begin
      hq = '0;
    end else if (hq_wide > (mh_pkg::H_W-17)'(16'hFFFF)) begin
      hq = 16'hFFFF;
    end else begin
      hq = hq_wide[15:0];
    end
  end

  assign out_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_ready) begin
      result.valid <= wrap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && wrap_valid) begin
      result.heading_rad  <= hq;
      result.x_calibrated <= wrap_side.xc;
      result.y_calibrated <= wrap_side.yc;
      result.z_out        <= wrap_side.zr;
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.heading_rad <= 16'd51472)
    else $error("heading beyond two pi");

  a_cal_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.x_calibrated >= -14'sd8191) &&
                     (result.y_calibrated >= -14'sd8191))
    else $error("calibrated axis out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_wrap_hold: assert property (@(posedge clk) disable iff (rst)
    wrap_valid && !out_ready |=> wrap_valid && $stable(wrap_h))
    else $error("wrap stage lost its word on stall");

endmodule

// ===== dv/heading_check.sv =====
// ----------------------------------------------------------------------------
// heading_check
// Watches the sample, result and register ports of magnetometer_heading. For
// every accepted sample it computes the calibrated axes and the CORDIC
// heading with its own copy of the offsets and declination, queues that word,
// and compares each accepted result field by field with the oldest queued
// word. Counts mismatches and the words still in flight for the top level.
// ----------------------------------------------------------------------------
module heading_check #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  mh_in_if            sample,
  mh_out_if           result,
  output int          mismatches,
  output int          outstanding
);

  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint PI_SCALED = 64'sd3373259426;
  localparam longint TWO_PI    = 64'sd6746518852;
  localparam longint CENTIDEG  = 64'sd18000;

  typedef struct packed {
    logic        [15:0] heading;
    logic signed [13:0] x_cal;
    logic signed [13:0] y_cal;
    logic signed [12:0] z;
  } heading_word_t;

  heading_word_t      heading_q[$];
  logic signed [12:0] x_offset;
  logic signed [12:0] y_offset;
  logic signed [15:0] declination;

  function automatic longint arctan_step(int i);
    case (i)
      0:       return 843314856;
      1:       return 497837829;
      2:       return 263043836;
      3:       return 133525158;
      4:       return 67021686;
      5:       return 33543515;
      6:       return 16775850;
      7:       return 8388437;
      8:       return 4194282;
      9:       return 2097149;
      10:      return 1048575;
      11:      return 524287;
      12:      return 262143;
      13:      return 131071;
      14:      return 65535;
      15:      return 32767;
      16:      return 16383;
      17:      return 8191;
      18:      return 4095;
      19:      return 2047;
      20:      return 1023;
      21:      return 511;
      22:      return 255;
      23:      return 127;
      default: return 0;
    endcase
  endfunction

  function automatic longint declination_angle(longint d);
    longint mag;
    longint r;
    mag = (d < 0) ? -d : d;
    r = (mag * PI_SCALED + CENTIDEG / 2) / CENTIDEG;
    return (d < 0) ? -r : r;
  endfunction

  function automatic logic [15:0] heading_of(longint xc, longint yc, longint decl);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    longint h;
    int     steps;
    z = 0;
    steps = (ITERATIONS > 24) ? 24 : ITERATIONS;
    if (xc != 0 || yc != 0) begin
      x = xc * 65536;
      y = yc * 65536;
      // fold into the right half plane
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = HALF_PI;
        end else begin
          x = -y;
          y = t;
          z = -HALF_PI;
        end
      end
      for (int i = 0; i < steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += arctan_step(i);
        end else begin
          x -= dx;
          y += dy;
          z -= arctan_step(i);
        end
      end
    end
    h = z + declination_angle(decl);
    if (h < 0) h += TWO_PI;
    else if (h > TWO_PI) h -= TWO_PI;
    if (h < 0) return '0;
    h = (h + 65536) >>> 17;
    return (h > 65535) ? 16'hFFFF : h[15:0];
  endfunction

  function automatic heading_word_t predict(logic signed [12:0] xr, logic signed [12:0] zr,
                                            logic signed [12:0] yr);
    longint        xc;
    longint        yc;
    heading_word_t w;
    xc = longint'(xr) - longint'(x_offset);
    yc = longint'(yr) - longint'(y_offset);
    w.heading = heading_of(xc, yc, longint'(declination));
    w.x_cal   = xc[13:0];
    w.y_cal   = yc[13:0];
    w.z       = zr;
    return w;
  endfunction

  function automatic void report(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    heading_word_t want;
    if (rst) begin
      heading_q.delete();
      x_offset    = '0;
      y_offset    = '0;
      declination = '0;
      mismatches  = 0;
    end else begin
      if (sample.valid && sample.ready)
        heading_q.push_back(predict(sample.x_raw, sample.z_raw, sample.y_raw));
      if (result.valid && result.ready) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual heading %0d x %0d y %0d z %0d",
                   $time, result.heading_rad, result.x_calibrated, result.y_calibrated,
                   result.z_out);
          mismatches++;
        end else begin
          want = heading_q.pop_front();
          if (result.heading_rad !== want.heading)
            report("heading_rad", want.heading, result.heading_rad);
          if (result.x_calibrated !== want.x_cal)
            report("x_calibrated", want.x_cal, result.x_calibrated);
          if (result.y_calibrated !== want.y_cal)
            report("y_calibrated", want.y_cal, result.y_calibrated);
          if (result.z_out !== want.z)
            report("z_out", want.z, result.z_out);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          mh_pkg::REG_X_OFFSET:    x_offset    = cfg_data[12:0];
          mh_pkg::REG_Y_OFFSET:    y_offset    = cfg_data[12:0];
          mh_pkg::REG_DECLINATION: declination = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = heading_q.size();
  end

endmodule

// ===== dv/tb_magnetometer_heading.sv =====
// ----------------------------------------------------------------------------
// tb_magnetometer_heading
// Drives magnetometer_heading with directed corner samples and then random
// samples under several offset and declination settings, with random source
// gaps and sink stalls; heading_check predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_magnetometer_heading;

  localparam int         ITERS       = 16;
  localparam int         QUIET_LIMIT = 4000;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic signed [12:0] xo_cur;
  logic signed [12:0] yo_cur;
  int                 src_idle_pct;
  int                 snk_stall_pct;
  int                 mismatches;
  int                 outstanding;
  int                 quiet_cycles;

  mh_in_if  sample_ch ();
  mh_out_if result_ch ();

  magnetometer_heading #(
    .CORDIC_ITERATIONS(ITERS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  heading_check #(
    .ITERATIONS(ITERS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample_ch),
    .result      (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic signed [12:0] x, logic signed [12:0] z,
                             logic signed [12:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.x_raw = x;
    sample_ch.z_raw = z;
    sample_ch.y_raw = y;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [12:0] corner_value();
    case ($urandom_range(3))
      0:       return 13'sd4095;
      1:       return -13'sd4096;
      2:       return 13'sd0;
      default: return -13'sd1;
    endcase
  endfunction

  task automatic send_random();
    logic signed [12:0] x;
    logic signed [12:0] y;
    case ($urandom_range(9))
      0: begin
        // land near or on the zero vector after calibration
        x = xo_cur + 13'($urandom_range(6)) - 13'd3;
        y = yo_cur + 13'($urandom_range(6)) - 13'd3;
      end
      1: begin
        x = corner_value();
        y = corner_value();
      end
      default: begin
        x = 13'($urandom);
        y = 13'($urandom);
      end
    endcase
    send_sample(x, 13'($urandom), y);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
  endtask

  task automatic reconfigure(int phase);
    logic signed [15:0] decl;
    sample_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (ITERS + 8) @(negedge clk);
    xo_cur = 13'($urandom);
    yo_cur = 13'($urandom);
    case (phase)
      0: begin
        xo_cur = 13'sd4095;
        yo_cur = -13'sd4096;
        decl   = 16'sd18000;
      end
      1: begin
        xo_cur = -13'sd4096;
        yo_cur = 13'sd4095;
        decl   = -16'sd18000;
      end
      2: begin
        xo_cur = '0;
        yo_cur = '0;
        decl   = 16'sd32767;
      end
      3:       decl = -16'sd32768;
      4:       decl = 16'($urandom_range(36000)) - 16'd18000;
      5:       decl = 16'($urandom);
      6: begin
        xo_cur = '0;
        yo_cur = '0;
        decl   = '0;
      end
      default: decl = '0;
    endcase
    write_reg(REG_SPARE, 16'($urandom));
    write_reg(mh_pkg::REG_X_OFFSET, {3'($urandom), xo_cur});
    write_reg(mh_pkg::REG_Y_OFFSET, {3'($urandom), yo_cur});
    write_reg(mh_pkg::REG_DECLINATION, decl);
    cfg_wr_en = 1'b0;
    // let the declination reach the heading path
    repeat (8) @(negedge clk);
  endtask

  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = mh_pkg::REG_X_OFFSET;
    cfg_data        = '0;
    sample_ch.valid = 1'b0;
    sample_ch.x_raw = '0;
    sample_ch.z_raw = '0;
    sample_ch.y_raw = '0;
    result_ch.ready = 1'b0;
    xo_cur          = '0;
    yo_cur          = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    quiet_cycles    = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    send_sample(13'sd0, 13'sd0, 13'sd0);
    send_sample(13'sd4095, 13'sd4095, 13'sd0);
    send_sample(13'sd0, -13'sd4096, 13'sd4095);
    send_sample(-13'sd4096, 13'sd0, 13'sd0);
    send_sample(13'sd0, 13'sd4095, -13'sd4096);
    send_sample(13'sd4095, -13'sd4096, 13'sd4095);
    send_sample(-13'sd4096, -13'sd1, -13'sd4096);
    send_sample(-13'sd4096, 13'sd1, 13'sd4095);
    send_sample(13'sd4095, 13'sd4095, -13'sd4096);
    send_sample(13'sd1, -13'sd4096, 13'sd0);
    send_sample(13'sd0, 13'sd0, 13'sd1);
    send_sample(-13'sd1, 13'sd4095, 13'sd0);
    send_sample(13'sd0, -13'sd4096, -13'sd1);
    send_sample(-13'sd1, 13'($urandom), -13'sd1);
    send_sample(13'sd1, 13'($urandom), -13'sd1);
    send_sample(13'sd4095, 13'($urandom), -13'sd1);
    send_sample(13'sd2730, 13'($urandom), -13'sd2730);

    for (int phase = 0; phase < 8; phase++) begin
      reconfigure(phase);
      case (phase % 4)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 48;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 48;
        end
        default: begin
          src_idle_pct  = 31;
          snk_stall_pct = 31;
        end
      endcase
      repeat (67) send_random();
    end

    sample_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (ITERS + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
